>>> sv/lcr_pkg.sv
// ----------------------------------------------------------------------------
// Linear column resampler package
// Shared types and constants: request payloads, configuration, job records.
// ----------------------------------------------------------------------------
package lcr_pkg;

  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned SPC_W       = 16;
  localparam int unsigned POS_W       = 26;
  localparam int unsigned OFFS_W      = 24;
  localparam int unsigned WGT_W       = 16;
  localparam int unsigned IB_W        = 7;
  localparam int unsigned QUO_W       = IB_W + WGT_W;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_OLD_COUNT     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEW_COUNT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OLD_SPACING   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEW_SPACING   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_FORMAT = 3'd4;

  typedef enum logic [1:0] {
    KIND_INTERP,
    KIND_LOW,
    KIND_HIGH,
    KIND_ZERO
  } job_kind_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          last_value;
  } out_item_t;

  // counts clamped to 2..MAX_SLICES, spacings forced nonzero
  typedef struct packed {
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] m;
    logic [SPC_W-1:0] so;
    logic [SPC_W-1:0] sn;
    logic             fmt;
  } cfg_t;

  typedef struct packed {
    job_kind_e         kind;
    logic [OFFS_W-1:0] offs;
    logic              last;
  } job_t;

endpackage

>>> sv/lcr_fifo.sv
// ----------------------------------------------------------------------------
// Linear column resampler queue
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module lcr_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  T                   entries_q [DEPTH];
  logic [PTR_W-1:0]   wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entries_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wptr_q] <= data_i;
    end
  end

endmodule

>>> sv/lcr_front.sv
// ----------------------------------------------------------------------------
// Linear column resampler front end
// Loads column samples into the store; at column end places each output on
// the new grid and classifies it into one job for the back end.
// ----------------------------------------------------------------------------
module lcr_front #(
  parameter int unsigned MAX_SLICES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lcr_pkg::cfg_t                     cfg_i,
  input  logic                              push_i,
  input  lcr_pkg::in_item_t                 item_i,
  output logic                              full_o,
  output logic                              wr_en_o,
  output logic [$clog2(MAX_SLICES)-1:0]     wr_addr_o,
  output logic [lcr_pkg::SAMPLE_BITS-1:0]   wr_data_o,
  output logic                              job_push_o,
  output lcr_pkg::job_t                     job_o,
  input  logic                              job_full_i,
  input  logic                              col_done_i
);

  import lcr_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_SLICES);
  localparam int unsigned LOAD_W = $clog2(MAX_SLICES + 1);

  localparam logic [2:0] FS_LOAD = 3'd0;
  localparam logic [2:0] FS_PREP = 3'd1;
  localparam logic [2:0] FS_MUL  = 3'd2;
  localparam logic [2:0] FS_PUSH = 3'd3;
  localparam logic [2:0] FS_WAIT = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [LOAD_W-1:0]       load_idx_q, load_idx_d;
  logic [CNT_W-1:0]        idx_q, idx_d;
  logic [2*CNT_W+8:0]      nso_q, nso_d;
  logic signed [POS_W-1:0] x_q, x_d;

  logic                    accept;
  logic signed [8:0]       tpos;
  logic signed [POS_W-1:0] first, last, so_ext, lo_gap, hi_gap, offs;

  assign full_o = (state_q != FS_LOAD);
  assign accept = push_i && !full_o;

  assign wr_en_o   = accept && (32'(load_idx_q) < MAX_SLICES);
  assign wr_addr_o = load_idx_q[IDX_W-1:0];
  assign wr_data_o = cfg_i.fmt ? {8'h00, item_i.sample[7:0]} : item_i.sample;

  // doubled positions: output at (2i - m) * sn, inputs from -n*so to (n-2)*so
  assign tpos   = $signed({1'b0, idx_q, 1'b0}) - $signed({2'b00, cfg_i.m});
  assign x_d    = tpos * $signed({1'b0, cfg_i.sn});
  assign nso_d  = cfg_i.n * cfg_i.so;
  assign so_ext = $signed({{(POS_W-SPC_W){1'b0}}, cfg_i.so});
  assign first  = -$signed({3'b000, nso_q});
  assign last   = $signed({3'b000, nso_q}) - (so_ext <<< 1);
  assign lo_gap = first - x_q;
  assign hi_gap = x_q - last;
  assign offs   = x_q - first;

  always_comb begin
    job_o.last = (idx_q == cfg_i.m - 1'b1);
    job_o.offs = offs[OFFS_W-1:0];
    if (x_q < first) begin
      job_o.kind = (lo_gap <= so_ext) ? KIND_LOW : KIND_ZERO;
    end else if (x_q > last) begin
      job_o.kind = (hi_gap <= so_ext) ? KIND_HIGH : KIND_ZERO;
    end else begin
      job_o.kind = KIND_INTERP;
    end
  end

  assign job_push_o = (state_q == FS_PUSH) && !job_full_i;

  always_comb begin
    state_d    = state_q;
    load_idx_d = load_idx_q;
    idx_d      = idx_q;
    unique case (state_q)
      FS_LOAD: begin
        if (accept) begin
          if (wr_en_o) begin
            load_idx_d = load_idx_q + 1'b1;
          end
          if (item_i.last_sample) begin
            load_idx_d = '0;
            idx_d      = '0;
            state_d    = FS_PREP;
          end
        end
      end
      FS_PREP: state_d = FS_MUL;
      FS_MUL:  state_d = FS_PUSH;
      FS_PUSH: begin
        if (!job_full_i) begin
          if (job_o.last) begin
            state_d = FS_WAIT;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = FS_MUL;
          end
        end
      end
      FS_WAIT: begin
        if (col_done_i) begin
          state_d = FS_LOAD;
        end
      end
      default: state_d = FS_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FS_LOAD;
      load_idx_q <= '0;
      idx_q      <= '0;
    end else begin
      state_q    <= state_d;
      load_idx_q <= load_idx_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FS_PREP) begin
      nso_q <= nso_d;
    end
    if (state_q == FS_MUL) begin
      x_q <= x_d;
    end
  end

endmodule

>>> sv/lcr_back.sv
// ----------------------------------------------------------------------------
// Linear column resampler back end
// Holds the column store; for interpolation jobs runs a bit-serial divide for
// bracket and weight, then reads both neighbors, interpolates, rounds and clamps.
// ----------------------------------------------------------------------------
module lcr_back #(
  parameter int unsigned MAX_SLICES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lcr_pkg::cfg_t                     cfg_i,
  input  logic                              wr_en_i,
  input  logic [$clog2(MAX_SLICES)-1:0]     wr_addr_i,
  input  logic [lcr_pkg::SAMPLE_BITS-1:0]   wr_data_i,
  input  lcr_pkg::job_t                     job_i,
  input  logic                              job_empty_i,
  output logic                              job_pop_o,
  output logic                              out_push_o,
  output lcr_pkg::out_item_t                out_o,
  input  logic                              out_full_i,
  output logic                              col_done_o
);

  import lcr_pkg::*;

  localparam int unsigned IDX_W  = $clog2(MAX_SLICES);
  localparam int unsigned STEP_W = $clog2(QUO_W + 1);
  localparam int unsigned REM_W  = SPC_W + 1;
  localparam int unsigned ACC_W  = 35;
  localparam int unsigned RES_W  = ACC_W - WGT_W;

  localparam logic [2:0] BS_IDLE = 3'd0;
  localparam logic [2:0] BS_DIV  = 3'd1;
  localparam logic [2:0] BS_RD0  = 3'd2;
  localparam logic [2:0] BS_RD1  = 3'd3;
  localparam logic [2:0] BS_MUL  = 3'd4;
  localparam logic [2:0] BS_SUM  = 3'd5;
  localparam logic [2:0] BS_OUT  = 3'd6;

  localparam logic signed [RES_W-1:0] S_MIN = -RES_W'(32768);
  localparam logic signed [RES_W-1:0] S_MAX = RES_W'(32767);
  localparam logic signed [RES_W-1:0] U_MAX = RES_W'(255);

  logic signed [SAMPLE_BITS-1:0] mem_q [MAX_SLICES];
  logic signed [SAMPLE_BITS-1:0] rd_data_q;
  logic [IDX_W-1:0]              rd_addr;

  logic [2:0]                    state_q, state_d;
  logic [REM_W-1:0]              rem_q, rem_d;
  logic [QUO_W-1:0]              sh_q, sh_d, quo_q, quo_d;
  logic [STEP_W-1:0]             step_q, step_d;
  logic                          zero_q, zero_d, last_q, last_d;
  logic signed [SAMPLE_BITS-1:0] v0_q, res_q, res_d;
  logic signed [2*SAMPLE_BITS+1:0] prod_q, prod_d;

  logic [REM_W:0]                trial;
  logic [REM_W-1:0]              sp2;
  logic                          ge;
  logic [IB_W-1:0]               ib;
  logic [WGT_W-1:0]              w1;
  logic [IB_W:0]                 ib_next;
  logic signed [SAMPLE_BITS-1:0] v1;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [ACC_W-1:0]       acc;
  logic signed [RES_W-1:0]       rnd;

  assign ib      = quo_q[QUO_W-1:WGT_W];
  assign w1      = quo_q[WGT_W-1:0];
  assign ib_next = {1'b0, ib} + 1'b1;
  assign rd_addr = (state_q == BS_RD1) ? IDX_W'(ib_next) : IDX_W'(ib);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // restoring divide: floor(offs * 2^16 / (2*so)) = {bracket, weight}
  assign sp2   = {cfg_i.so, 1'b0};
  assign trial = {rem_q, sh_q[QUO_W-1]};
  assign ge    = (trial >= {1'b0, sp2});

  assign v1     = (ib_next < {1'b0, cfg_i.n}) ? rd_data_q : v0_q;
  assign diff   = $signed({v1[SAMPLE_BITS-1], v1}) - $signed({v0_q[SAMPLE_BITS-1], v0_q});
  assign prod_d = diff * $signed({1'b0, w1});
  assign acc    = ACC_W'($signed({v0_q, 16'h0000})) + ACC_W'(prod_q)
                + ACC_W'(33'sd32768);
  assign rnd    = acc[ACC_W-1:WGT_W];

  always_comb begin
    if (cfg_i.fmt) begin
      if (rnd < 0) begin
        res_d = '0;
      end else if (rnd > U_MAX) begin
        res_d = SAMPLE_BITS'(U_MAX);
      end else begin
        res_d = SAMPLE_BITS'(rnd);
      end
    end else begin
      if (rnd < S_MIN) begin
        res_d = SAMPLE_BITS'(S_MIN);
      end else if (rnd > S_MAX) begin
        res_d = SAMPLE_BITS'(S_MAX);
      end else begin
        res_d = SAMPLE_BITS'(rnd);
      end
    end
  end

  assign job_pop_o   = (state_q == BS_IDLE) && !job_empty_i;
  assign out_push_o  = (state_q == BS_OUT) && !out_full_i;
  assign out_o.value = zero_q ? '0 : res_q;
  assign out_o.last_value = last_q;
  assign col_done_o  = out_push_o && last_q;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    sh_d    = sh_q;
    quo_d   = quo_q;
    step_d  = step_q;
    zero_d  = zero_q;
    last_d  = last_q;
    unique case (state_q)
      BS_IDLE: begin
        if (!job_empty_i) begin
          last_d = job_i.last;
          zero_d = 1'b0;
          unique case (job_i.kind)
            KIND_INTERP: begin
              rem_d   = REM_W'(job_i.offs[OFFS_W-1:IB_W]);
              sh_d    = {job_i.offs[IB_W-1:0], {WGT_W{1'b0}}};
              step_d  = STEP_W'(QUO_W);
              state_d = BS_DIV;
            end
            KIND_LOW: begin
              quo_d   = '0;
              state_d = BS_RD0;
            end
            KIND_HIGH: begin
              quo_d   = {cfg_i.n - 1'b1, {WGT_W{1'b0}}};
              state_d = BS_RD0;
            end
            default: begin
              zero_d  = 1'b1;
              state_d = BS_OUT;
            end
          endcase
        end
      end
      BS_DIV: begin
        rem_d  = ge ? REM_W'(trial - {1'b0, sp2}) : REM_W'(trial);
        sh_d   = {sh_q[QUO_W-2:0], 1'b0};
        quo_d  = {quo_q[QUO_W-2:0], ge};
        step_d = step_q - 1'b1;
        if (step_q == STEP_W'(1)) begin
          state_d = BS_RD0;
        end
      end
      BS_RD0:  state_d = BS_RD1;
      BS_RD1:  state_d = BS_MUL;
      BS_MUL:  state_d = BS_SUM;
      BS_SUM:  state_d = BS_OUT;
      BS_OUT: begin
        if (!out_full_i) begin
          state_d = BS_IDLE;
        end
      end
      default: state_d = BS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    sh_q   <= sh_d;
    quo_q  <= quo_d;
    zero_q <= zero_d;
    last_q <= last_d;
    if (state_q == BS_RD1) begin
      v0_q <= rd_data_q;
    end
    if (state_q == BS_MUL) begin
      prod_q <= prod_d;
    end
    if (state_q == BS_SUM) begin
      res_q <= res_d;
    end
  end

endmodule

>>> sv/linear_column_resampler.sv
// ----------------------------------------------------------------------------
// Linear column resampler
// Loads a column of samples on a centered grid and emits it resampled onto a
// second centered grid by linear interpolation, rounded and clamped.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake               Payload
//  input     in   push / full             in_item_i  (sample, last_sample)
//  result    out  empty / pop             out_item_o (value, last_value)
//  config    in   cfg_we_i, cfg_idx_i     cfg_wdata_i
//
//  Samples are taken one per cycle while a column loads. After the last
//  sample, full stays high until the back end has read the store for every
//  output (each interpolated output first runs a 23-step serial divider);
//  results wait in a 2-entry queue. Reset returns the control and config
//  registers to defaults; the column store is not cleared.
// ----------------------------------------------------------------------------
module linear_column_resampler #(
  parameter int unsigned MAX_SLICES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  input  lcr_pkg::in_item_t                 in_item_i,
  output logic                              full,
  output logic                              empty,
  input  logic                              pop,
  output lcr_pkg::out_item_t                out_item_o,
  input  logic                              cfg_we_i,
  input  logic [lcr_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lcr_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  import lcr_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_SLICES);

  logic [CNT_W-1:0] old_count_q, new_count_q;
  logic [SPC_W-1:0] old_spacing_q, new_spacing_q;
  logic             sample_format_q;
  cfg_t             cfg;

  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [SAMPLE_BITS-1:0] wr_data;
  logic                   job_push, job_full, job_pop, job_empty;
  job_t                   job_in, job_out;
  logic                   out_push, out_full, col_done;
  out_item_t              out_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      old_count_q     <= CNT_W'(2);
      new_count_q     <= CNT_W'(2);
      old_spacing_q   <= SPC_W'(256);
      new_spacing_q   <= SPC_W'(256);
      sample_format_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OLD_COUNT:     old_count_q     <= cfg_wdata_i[CNT_W-1:0];
        REG_NEW_COUNT:     new_count_q     <= cfg_wdata_i[CNT_W-1:0];
        REG_OLD_SPACING:   old_spacing_q   <= cfg_wdata_i[SPC_W-1:0];
        REG_NEW_SPACING:   new_spacing_q   <= cfg_wdata_i[SPC_W-1:0];
        REG_SAMPLE_FORMAT: sample_format_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = c;
    if (c < CNT_W'(2)) begin
      r = CNT_W'(2);
    end else if (32'(c) > MAX_SLICES) begin
      r = CNT_W'(MAX_SLICES);
    end
    return r;
  endfunction

  assign cfg.n   = clamp_count(old_count_q);
  assign cfg.m   = clamp_count(new_count_q);
  assign cfg.so  = (old_spacing_q == '0) ? SPC_W'(1) : old_spacing_q;
  assign cfg.sn  = (new_spacing_q == '0) ? SPC_W'(1) : new_spacing_q;
  assign cfg.fmt = sample_format_q;

  lcr_front #(
    .MAX_SLICES (MAX_SLICES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .push_i     (push),
    .item_i     (in_item_i),
    .full_o     (full),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .job_push_o (job_push),
    .job_o      (job_in),
    .job_full_i (job_full),
    .col_done_i (col_done)
  );

  lcr_fifo #(
    .T     (job_t),
    .DEPTH (4)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (job_full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  lcr_back #(
    .MAX_SLICES (MAX_SLICES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .job_i       (job_out),
    .job_empty_i (job_empty),
    .job_pop_o   (job_pop),
    .out_push_o  (out_push),
    .out_o       (out_in),
    .out_full_i  (out_full),
    .col_done_o  (col_done)
  );

  lcr_fifo #(
    .T     (out_item_t),
    .DEPTH (2)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  (out_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  (out_item_o),
    .empty_o (empty)
  );

`ifndef NO_ASSERTIONS
  a_load_no_jobs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> job_empty)
    else $error("input open while jobs of a column are pending");

  a_done_reopens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_done |=> !full)
    else $error("input stays closed after column done");

  a_job_pop_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> !job_empty)
    else $error("job popped from empty queue");

  a_store_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (job_empty && !col_done))
    else $error("store written while back end is busy");
`endif

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Linear column resampler testbench
// Streams sample columns through the resampler under many register settings
// and checks every output request, field by field, against a predictor of the
// resampling arithmetic. Both handshake sides idle at random, and the output
// side holds off for long stretches so the input side backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

  import lcr_pkg::*;

  localparam int STORE_DEPTH = 64;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 600;

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  push        = 1'b0;
  in_item_t              in_item_i   = '0;
  logic                  full;
  logic                  empty;
  logic                  pop         = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  linear_column_resampler #(
    .MAX_SLICES(STORE_DEPTH)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .in_item_i  (in_item_i),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // predictor state
  logic [CNT_W-1:0] old_cnt_r = 7'd2;
  logic [CNT_W-1:0] new_cnt_r = 7'd2;
  logic [SPC_W-1:0] old_sp_r  = 16'd256;
  logic [SPC_W-1:0] new_sp_r  = 16'd256;
  logic             fmt_r     = 1'b0;
  longint           column_mem [STORE_DEPTH];
  int               load_idx  = 0;

  in_item_t  sample_queue [$];
  out_item_t expected_values [$];

  int samples_in   = 0;
  int columns_done = 0;
  int results_seen = 0;
  int mismatches   = 0;
  int settings_run = 0;
  int holds_done   = 0;
  int quiet_cycles = 0;

  int tx_gap  = 0;
  int tx_calm = 0;
  int rx_gap  = 0;
  int rx_calm = 0;
  int hold_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint eff_count(logic [CNT_W-1:0] c);
    if (c < 2) return 2;
    if (c > STORE_DEPTH) return STORE_DEPTH;
    return longint'(c);
  endfunction

  function automatic longint round_clamp(longint acc);
    longint r;
    r = (acc + 64'sd32768) >>> 16;
    if (fmt_r) begin
      if (r < 0) r = 0;
      if (r > 255) r = 255;
    end else begin
      if (r < -32768) r = -32768;
      if (r > 32767) r = 32767;
    end
    return r;
  endfunction

  function automatic void resample_column();
    longint n, m, so, sn, sp2, first_pos, last_pos;
    longint x, d, ib, rem, w1, v0, v1, v;
    out_item_t o;
    n = eff_count(old_cnt_r);
    m = eff_count(new_cnt_r);
    so = (old_sp_r == 0) ? 1 : longint'(old_sp_r);
    sn = (new_sp_r == 0) ? 1 : longint'(new_sp_r);
    sp2 = 2 * so;
    first_pos = -n * so;
    last_pos = (n - 2) * so;
    for (longint i = 0; i < m; i++) begin
      x = (2 * i - m) * sn;
      v = 0;
      if (x < first_pos) begin
        if (first_pos - x <= so) v = round_clamp(column_mem[0] * 65536);
      end else if (x > last_pos) begin
        if (x - last_pos <= so) v = round_clamp(column_mem[n-1] * 65536);
      end else begin
        d = x - first_pos;
        ib = d / sp2;
        rem = d - ib * sp2;
        if (ib >= n - 1) begin
          ib = n - 1;
          rem = 0;
        end
        w1 = (rem * 65536) / sp2;
        v0 = column_mem[ib];
        v1 = (ib + 1 < n) ? column_mem[ib+1] : v0;
        v = round_clamp(v0 * (65536 - w1) + v1 * w1);
      end
      o.value = v[15:0];
      o.last_value = (i == m - 1);
      expected_values.push_back(o);
    end
  endfunction

  function automatic void load_sample(in_item_t it);
    if (load_idx < STORE_DEPTH) begin
      column_mem[load_idx] = fmt_r ? longint'({8'd0, it.sample[7:0]})
                                   : longint'($signed(it.sample));
      load_idx++;
    end
    samples_in++;
    if (it.last_sample) begin
      load_idx = 0;
      columns_done++;
      resample_column();
    end
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic note_mismatch(input string what, input longint want, input longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on result %0d: %s expected 0x%0h got 0x%0h",
               results_seen, what, want, got);
  endtask

  // input side: drive requests, feed accepted ones to the predictor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) load_sample(in_item_i);
      if (push && full) begin
      end else if (tx_gap > 0) begin
        tx_gap--;
        push <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        in_item_i <= sample_queue.pop_front();
        push <= 1'b1;
        if (tx_calm > 0) begin
          tx_calm--;
          tx_gap = 0;
        end else begin
          tx_gap = draw_gap();
          if ($urandom_range(0, 19) == 0) tx_calm = $urandom_range(20, 60);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // output side: accept and check requests, stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        results_seen++;
        if (expected_values.size() == 0) begin
          note_mismatch("unexpected request, value", 0, out_item_o.value);
        end else begin
          if (out_item_o.value !== expected_values[0].value)
            note_mismatch("value", expected_values[0].value, out_item_o.value);
          if (out_item_o.last_value !== expected_values[0].last_value)
            note_mismatch("last_value", expected_values[0].last_value,
                          out_item_o.last_value);
          void'(expected_values.pop_front());
        end
        if (rx_calm > 0) begin
          rx_calm--;
          rx_gap = 0;
        end else begin
          rx_gap = draw_gap();
          if ($urandom_range(0, 19) == 0) rx_calm = $urandom_range(20, 60);
        end
        if (holds_done < 2 && results_seen >= (holds_done == 0 ? 40 : 1200) &&
            expected_values.size() > 4 && sample_queue.size() > 0) begin
          hold_left = HOLD_CYCLES;
          holds_done++;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_OLD_COUNT:     old_cnt_r = data[6:0];
      REG_NEW_COUNT:     new_cnt_r = data[6:0];
      REG_OLD_SPACING:   old_sp_r  = data;
      REG_NEW_SPACING:   new_sp_r  = data;
      REG_SAMPLE_FORMAT: fmt_r     = data[0];
      default: ;
    endcase
  endtask

  task automatic add_item(input logic [15:0] s, input logic l);
    in_item_t it;
    it.sample = s;
    it.last_sample = l;
    sample_queue.push_back(it);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (sample_queue.size() != 0 || push || expected_values.size() != 0)
      @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return {8'($urandom_range(0, 255)), 8'hFF};
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic queue_column(input int len, input bit closed);
    for (int k = 0; k < len; k++) add_item(pick_sample(), closed && (k == len - 1));
  endtask

  function automatic logic [15:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 16'($urandom_range(2, 10));
    if (r < 75) return 16'($urandom_range(11, 63));
    if (r < 85) return 16'd64;
    if (r < 90) return 16'($urandom_range(0, 1));
    if (r < 95) return 16'($urandom_range(65, 127));
    return {9'($urandom_range(1, 511)), 7'($urandom_range(2, 8))};
  endfunction

  function automatic logic [15:0] pick_spacing();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 16'd0;
    if (r < 16) return 16'hFFFF;
    if (r < 24) return 16'($urandom_range(1, 4));
    if (r < 50) return 16'(256 * $urandom_range(1, 8));
    return 16'($urandom_range(1, 65535));
  endfunction

  logic [15:0] nc, mc, so_v, sn_v;
  logic        fmt_v;
  longint      derived;
  int          rand_items, phase_items, budget, len, phase_no;

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // exact grid points at the default settings
    add_item(16'h7FFF, 1'b0);
    add_item(16'h8000, 1'b1);
    wait_idle();
    // edge copies at exactly half a spacing, midpoint interpolation
    write_reg(REG_NEW_COUNT, 16'd3);
    add_item(16'h8000, 1'b0);
    add_item(16'h7FFF, 1'b1);
    wait_idle();
    // outer points beyond the edge zone read zero
    write_reg(REG_NEW_SPACING, 16'h0200);
    add_item(16'h1234, 1'b0);
    add_item(16'hFFFF, 1'b1);
    wait_idle();
    // counts out of range, zero spacings, extra samples past old_count
    write_reg(REG_OLD_COUNT, 16'd0);
    write_reg(REG_NEW_COUNT, 16'd127);
    write_reg(REG_OLD_SPACING, 16'd0);
    write_reg(REG_NEW_SPACING, 16'd0);
    add_item(16'h0001, 1'b0);
    add_item(16'hFFFE, 1'b0);
    add_item(16'h5555, 1'b1);
    wait_idle();
    // byte samples, widest spacings, counts below range
    write_reg(REG_SAMPLE_FORMAT, 16'd1);
    write_reg(REG_OLD_COUNT, 16'd1);
    write_reg(REG_NEW_COUNT, 16'd1);
    write_reg(REG_OLD_SPACING, 16'hFFFF);
    write_reg(REG_NEW_SPACING, 16'hFFFF);
    add_item(16'hAA80, 1'b0);
    add_item(16'h00FF, 1'b1);
    wait_idle();
    // byte samples with rounding between grid points
    write_reg(REG_OLD_COUNT, 16'd3);
    write_reg(REG_NEW_COUNT, 16'd5);
    write_reg(REG_OLD_SPACING, 16'd256);
    write_reg(REG_NEW_SPACING, 16'd100);
    add_item(16'h7F00, 1'b0);
    add_item(16'h80FF, 1'b0);
    add_item(16'hFF7F, 1'b1);
    wait_idle();
    settings_run = 6;

    rand_items = 0;
    phase_no = 0;
    while (rand_items < 480) begin
      case (phase_no)
        0: begin
          nc = 16'd64; mc = 16'd64; so_v = 16'd256; sn_v = 16'd256; fmt_v = 1'b0;
        end
        1: begin
          nc = 16'd64; mc = 16'd64; so_v = 16'hFFFF; sn_v = 16'd1; fmt_v = 1'b1;
        end
        2: begin
          nc = 16'd2; mc = 16'd64; so_v = 16'd1; sn_v = 16'hFFFF; fmt_v = 1'b0;
        end
        default: begin
          nc = pick_count();
          mc = pick_count();
          so_v = pick_spacing();
          fmt_v = 1'($urandom_range(0, 1));
          if ($urandom_range(0, 9) < 4) begin
            derived = ((so_v == 0 ? 1 : longint'(so_v)) * eff_count(nc[6:0])) /
                      eff_count(mc[6:0]) + $urandom_range(0, 4) - 2;
            if (derived < 1) derived = 1;
            if (derived > 65535) derived = 65535;
            sn_v = derived[15:0];
          end else begin
            sn_v = pick_spacing();
          end
        end
      endcase
      write_reg(REG_OLD_COUNT, nc);
      write_reg(REG_NEW_COUNT, mc);
      write_reg(REG_OLD_SPACING, so_v);
      write_reg(REG_NEW_SPACING, sn_v);
      write_reg(REG_SAMPLE_FORMAT, {15'd0, fmt_v});
      settings_run++;

      phase_items = 0;
      // first column fills every store entry and may run past the end
      if (phase_no == 0) begin
        len = STORE_DEPTH + $urandom_range(0, 4);
        queue_column(len, 1'b1);
        phase_items += len;
      end
      budget = $urandom_range(25, 50);
      while (phase_items < budget) begin
        case ($urandom_range(0, 19))
          0, 1:   len = $urandom_range(1, eff_count(old_cnt_r) - 1);
          2, 3:   len = eff_count(old_cnt_r) + $urandom_range(1, 4);
          4:      len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 6);
          default: len = eff_count(old_cnt_r);
        endcase
        queue_column(len, 1'b1);
        phase_items += len;
      end
      // leave a column open across the next register change
      if ($urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 3);
        queue_column(len, 1'b0);
        phase_items += len;
      end
      rand_items += phase_items;
      phase_no++;
      wait_idle();
    end

    repeat (60) @(negedge clk_i);
    $display("covered %0d samples in %0d columns over %0d register settings",
             samples_in, columns_done, settings_run);
    $display("checked %0d output requests, %0d long receiver hold-offs, %0d mismatches",
             results_seen, holds_done, mismatches);
    if (mismatches == 0 && expected_values.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
